FILE: sv/i2cmw_pkg.sv
// ----------------------------------------------------------------------------
// i2cmw_pkg
// Types, codes and helpers shared by the I2C master write transmitter.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

  localparam int TIMER_BITS = 16;
  localparam int HP_W       = 16;
  localparam int ADDR_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [HP_W-1:0]       hp_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  localparam hp_t   HP_RESET   = 16'd30;
  localparam addr_t ADDR_RESET = 7'h68;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD = 1'd0,
    CFG_SLAVE_ADDR  = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_ADDR  = 3'd2,
    REQ_DATA  = 3'd3,
    REQ_STOP  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START_A = 3'd1,
    PH_START_B = 3'd2,
    PH_BIT_LO  = 3'd3,
    PH_BIT_HI  = 3'd4,
    PH_STOP_A  = 3'd5,
    PH_STOP_B  = 3'd6,
    PH_STOP_C  = 3'd7
  } phase_t;

  // one result beat, scl in bit 0
  typedef struct packed {
    logic nack;
    logic ack_done;
    logic busy;
    logic sda_drive;
    logic sda_out;
    logic scl_out;
  } res_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       sda_in;
  } item_t;

  // segment length in ticks; hold segments are half of a half period, never zero
  function automatic timer_t seg_len(hp_t hp, logic hold);
    logic [32:0] h;
    h = 33'(hp);
    if (h == 33'd0) h = 33'd1;
    if (h > TMAX) h = TMAX;
    if (hold) begin
      h = h >> 1;
      if (h == 33'd0) h = 33'd1;
    end
    return timer_t'(h);
  endfunction

endpackage

FILE: sv/i2cmw_core.sv
// ----------------------------------------------------------------------------
// i2cmw_core
// Bus sequencer: advances the line state by one tick per accepted beat and
// forms that tick's result.
// ----------------------------------------------------------------------------
module i2cmw_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2cmw_pkg::item_t item,
  input  i2cmw_pkg::hp_t   half_period,
  input  i2cmw_pkg::addr_t slave_address,
  output i2cmw_pkg::res_t  res
);

  i2cmw_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]        bit_idx_r, bit_idx_nxt;
  logic [7:0]        shift_r, shift_nxt;
  i2cmw_pkg::timer_t tick_r, tick_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              drv_r, drv_nxt;
  logic              nack_r, nack_nxt;

  i2cmw_pkg::timer_t tick_dec;
  logic              seg_end;
  logic [3:0]        bi_inc;
  logic [7:0]        addr_byte;
  logic              done;
  logic              nack_out;

  assign tick_dec  = (tick_r != '0) ? tick_r - 1'b1 : tick_r;
  assign seg_end   = (tick_dec == '0);
  assign bi_inc    = bit_idx_r + 4'd1;
  assign addr_byte = {slave_address, 1'b0};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      i2cmw_pkg::PH_IDLE: begin
        case (item.req_type)
          i2cmw_pkg::REQ_START: phase_nxt = i2cmw_pkg::PH_START_A;
          i2cmw_pkg::REQ_ADDR,
          i2cmw_pkg::REQ_DATA:  phase_nxt = i2cmw_pkg::PH_BIT_LO;
          i2cmw_pkg::REQ_STOP:  phase_nxt = i2cmw_pkg::PH_STOP_A;
          default:              phase_nxt = phase_r;
        endcase
      end
      i2cmw_pkg::PH_START_A: if (seg_end) phase_nxt = i2cmw_pkg::PH_START_B;
      i2cmw_pkg::PH_BIT_LO:  if (seg_end) phase_nxt = i2cmw_pkg::PH_BIT_HI;
      i2cmw_pkg::PH_BIT_HI: begin
        if (seg_end) begin
          phase_nxt = (bit_idx_r > 4'd7) ? i2cmw_pkg::PH_IDLE : i2cmw_pkg::PH_BIT_LO;
        end
      end
      i2cmw_pkg::PH_STOP_A:  if (seg_end) phase_nxt = i2cmw_pkg::PH_STOP_B;
      i2cmw_pkg::PH_STOP_B:  if (seg_end) phase_nxt = i2cmw_pkg::PH_STOP_C;
      default:               if (seg_end) phase_nxt = i2cmw_pkg::PH_IDLE;
    endcase
  end

  // line levels, counters and result
  always_comb begin
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    tick_nxt    = tick_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    drv_nxt     = drv_r;
    nack_nxt    = nack_r;
    done        = 1'b0;
    nack_out    = 1'b0;
    if (phase_r == i2cmw_pkg::PH_IDLE) begin
      case (item.req_type)
        i2cmw_pkg::REQ_START: begin
          sda_nxt  = 1'b0;
          drv_nxt  = 1'b1;
          tick_nxt = i2cmw_pkg::seg_len(half_period, 1'b0);
        end
        i2cmw_pkg::REQ_ADDR,
        i2cmw_pkg::REQ_DATA: begin
          shift_nxt   = (item.req_type == i2cmw_pkg::REQ_ADDR) ? addr_byte : item.data_byte;
          bit_idx_nxt = 4'd0;
          nack_nxt    = 1'b0;
          scl_nxt     = 1'b0;
          drv_nxt     = 1'b1;
          sda_nxt     = shift_nxt[7];
          tick_nxt    = i2cmw_pkg::seg_len(half_period, 1'b0);
        end
        i2cmw_pkg::REQ_STOP: begin
          scl_nxt  = 1'b0;
          sda_nxt  = 1'b0;
          drv_nxt  = 1'b1;
          tick_nxt = i2cmw_pkg::seg_len(half_period, 1'b0);
        end
        default: ;
      endcase
    end else begin
      // acknowledge clock high: any high sample is a nack
      if (phase_r == i2cmw_pkg::PH_BIT_HI && bit_idx_r == 4'd8)
        nack_nxt = nack_r | item.sda_in;
      tick_nxt = tick_dec;
      if (seg_end) begin
        case (phase_r)
          i2cmw_pkg::PH_START_A: begin
            scl_nxt  = 1'b0;
            tick_nxt = i2cmw_pkg::seg_len(half_period, 1'b1);
          end
          i2cmw_pkg::PH_BIT_LO: begin
            scl_nxt  = 1'b1;
            tick_nxt = i2cmw_pkg::seg_len(half_period, 1'b0);
          end
          i2cmw_pkg::PH_BIT_HI: begin
            scl_nxt = 1'b0;
            if (bit_idx_r < 4'd7) begin
              bit_idx_nxt = bi_inc;
              sda_nxt     = shift_r[3'd7 - bi_inc[2:0]];
              tick_nxt    = i2cmw_pkg::seg_len(half_period, 1'b0);
            end else if (bit_idx_r == 4'd7) begin
              bit_idx_nxt = 4'd8;
              drv_nxt     = 1'b0;
              sda_nxt     = 1'b1;
              tick_nxt    = i2cmw_pkg::seg_len(half_period, 1'b0);
            end else begin
              drv_nxt     = 1'b1;
              done        = 1'b1;
              nack_out    = nack_nxt;
              bit_idx_nxt = 4'd0;
            end
          end
          i2cmw_pkg::PH_STOP_A: begin
            scl_nxt  = 1'b1;
            tick_nxt = i2cmw_pkg::seg_len(half_period, 1'b0);
          end
          i2cmw_pkg::PH_STOP_B: begin
            sda_nxt  = 1'b1;
            tick_nxt = i2cmw_pkg::seg_len(half_period, 1'b1);
          end
          default: ;
        endcase
      end
    end
  end

  assign res.scl_out   = scl_nxt;
  assign res.sda_out   = sda_nxt;
  assign res.sda_drive = drv_nxt;
  assign res.busy      = (phase_nxt != i2cmw_pkg::PH_IDLE);
  assign res.ack_done  = done;
  assign res.nack      = nack_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cmw_pkg::PH_IDLE;
      bit_idx_r <= '0;
      shift_r   <= '0;
      tick_r    <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      drv_r     <= 1'b1;
      nack_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      tick_r    <= tick_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      drv_r     <= drv_nxt;
      nack_r    <= nack_nxt;
    end
  end

endmodule

FILE: sv/i2c_master_write_bitbang.sv
// ----------------------------------------------------------------------------
// i2c_master_write_bitbang
// Tick-driven I2C master write transmitter with stream ports.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat on in_* is one timer tick; while idle it may carry a
//   command (start, address+write, data byte, stop) and always carries the
//   sampled SDA level. Every input beat yields exactly one output beat on
//   out_* with SCL, SDA, SDA drive enable, busy, ack_done and nack.
//   Commands that arrive while busy are dropped.
//   out_tvalid rises in the cycle after an input beat is accepted. Throughput:
//   one beat per cycle while out_tready stays high; the sequencer state and
//   the output register are each updated on every accepted beat.
//   Stall: the output register holds its beat while out_tready is low, and
//   in_tready drops until that beat is taken; in_tready is high whenever the
//   output register is empty or being drained in the same cycle.
//   cfg_*: half_period (index 0) and slave_address (index 1), written while
//   idle; a new value applies from the next bus segment.
//   Reset (rst_n low, synchronous): bus idle with SCL and SDA high, SDA
//   driven, registers back to 30 ticks and address 0x68, output empty.
// ----------------------------------------------------------------------------
module i2c_master_write_bitbang (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [2:0] req_type, [10:3] data_byte, [11] sda_in, [15:12] zero
  input  logic [i2cmw_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] ack_done,
  // [5] nack, [7:6] zero
  output logic [i2cmw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                  cfg_we,
  input  logic [i2cmw_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [i2cmw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  i2cmw_pkg::hp_t   half_period_r;
  i2cmw_pkg::addr_t slave_addr_r;
  i2cmw_pkg::item_t item;
  i2cmw_pkg::res_t  res;
  i2cmw_pkg::res_t  res_r;
  logic             out_valid_r;
  logic             in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign item.req_type  = in_tdata[2:0];
  assign item.data_byte = in_tdata[10:3];
  assign item.sda_in    = in_tdata[11];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= i2cmw_pkg::HP_RESET;
      slave_addr_r  <= i2cmw_pkg::ADDR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        i2cmw_pkg::CFG_HALF_PERIOD: half_period_r <= cfg_wdata;
        i2cmw_pkg::CFG_SLAVE_ADDR:  slave_addr_r  <= cfg_wdata[i2cmw_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  i2cmw_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_acc),
    .item          (item),
    .half_period   (half_period_r),
    .slave_address (slave_addr_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

`ifndef SYNTH
  // ack report ends the byte: bus driven again and idle
  a_ack_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.ack_done |-> !res_r.busy && res_r.sda_drive)
    else $error("ack_done beat not idle with SDA driven");

  a_nack_with_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.nack |-> res_r.ack_done)
    else $error("nack reported outside ack_done beat");

  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.sda_drive |-> res_r.busy)
    else $error("SDA released while idle");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the tick-driven I2C master write transmitter.
// Every accepted tick runs through a local copy of the bus sequencer, and
// each output beat is compared field by field with the oldest predicted
// line state. The run starts from reset values, moves on to a short
// directed pass at the fastest clock, then runs random transactions over
// several half periods. It closes with the first ticks of a start at the
// longest half period.
// Both ports idle at random, and the receiver stalls for a long stretch at fixed beat counts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // request codes the block treats as no action
  localparam logic [2:0] REQ_SPARE_A = 3'd5;
  localparam logic [2:0] REQ_SPARE_B = 3'd6;
  localparam logic [2:0] REQ_SPARE_C = 3'd7;

  typedef enum {ACK_ALL, ACK_MIXED, NACK_ALL} ack_mode_t;

  class line_scoreboard;
    i2cmw_pkg::hp_t    half_period;
    i2cmw_pkg::addr_t  slave_addr;
    i2cmw_pkg::phase_t phase;
    logic [3:0]        bit_idx;
    logic [7:0]        shreg;
    i2cmw_pkg::timer_t ticks_left;
    logic              scl, sda, drv, nack_seen;
    i2cmw_pkg::res_t   expected_levels [$];
    int                errors;
    int                ticks_taken;
    int                beats_seen;

    function void reset_bus();
      half_period = i2cmw_pkg::HP_RESET;
      slave_addr  = i2cmw_pkg::ADDR_RESET;
      phase       = i2cmw_pkg::PH_IDLE;
      bit_idx     = '0;
      shreg       = '0;
      ticks_left  = '0;
      scl         = 1'b1;
      sda         = 1'b1;
      drv         = 1'b1;
      nack_seen   = 1'b0;
    endfunction

    function void write_reg(i2cmw_pkg::cfg_idx_t idx, logic [15:0] value);
      case (idx)
        i2cmw_pkg::CFG_HALF_PERIOD: half_period = value;
        i2cmw_pkg::CFG_SLAVE_ADDR:  slave_addr  = value[6:0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != i2cmw_pkg::PH_IDLE;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    // a zero period counts as one; holds are half of a half period, at least one tick
    function i2cmw_pkg::timer_t segment_ticks(bit hold);
      logic [16:0] h;
      h = {1'b0, half_period};
      if (h == 17'd0) h = 17'd1;
      if (hold) begin
        h = h >> 1;
        if (h == 17'd0) h = 17'd1;
      end
      return i2cmw_pkg::timer_t'(h);
    endfunction

    function void enter(i2cmw_pkg::phase_t p, bit hold);
      phase      = p;
      ticks_left = segment_ticks(hold);
    endfunction

    function void load_byte(logic [7:0] value);
      shreg     = value;
      bit_idx   = '0;
      nack_seen = 1'b0;
      scl       = 1'b0;
      drv       = 1'b1;
      sda       = value[7];
      enter(i2cmw_pkg::PH_BIT_LO, 1'b0);
    endfunction

    function void note_tick(logic [2:0] req, logic [7:0] data, logic sda_in);
      i2cmw_pkg::res_t r;
      logic done, nk;
      done = 1'b0;
      nk   = 1'b0;
      ticks_taken++;
      if (phase == i2cmw_pkg::PH_IDLE) begin
        case (req)
          i2cmw_pkg::REQ_START: begin
            sda = 1'b0;
            drv = 1'b1;
            enter(i2cmw_pkg::PH_START_A, 1'b0);
          end
          i2cmw_pkg::REQ_ADDR: load_byte({slave_addr, 1'b0});
          i2cmw_pkg::REQ_DATA: load_byte(data);
          i2cmw_pkg::REQ_STOP: begin
            scl = 1'b0;
            sda = 1'b0;
            drv = 1'b1;
            enter(i2cmw_pkg::PH_STOP_A, 1'b0);
          end
          default: ;
        endcase
      end else begin
        // acknowledge clock high: any high sample means nack
        if (phase == i2cmw_pkg::PH_BIT_HI && bit_idx == 4'd8)
          nack_seen = nack_seen | sda_in;
        if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
        if (ticks_left == '0) begin
          case (phase)
            i2cmw_pkg::PH_START_A: begin
              scl = 1'b0;
              enter(i2cmw_pkg::PH_START_B, 1'b1);
            end
            i2cmw_pkg::PH_BIT_LO: begin
              scl = 1'b1;
              enter(i2cmw_pkg::PH_BIT_HI, 1'b0);
            end
            i2cmw_pkg::PH_BIT_HI: begin
              scl = 1'b0;
              if (bit_idx < 4'd7) begin
                bit_idx = bit_idx + 1'b1;
                sda = shreg[3'd7 - bit_idx[2:0]];
                enter(i2cmw_pkg::PH_BIT_LO, 1'b0);
              end else if (bit_idx == 4'd7) begin
                bit_idx = 4'd8;
                drv = 1'b0;
                sda = 1'b1;
                enter(i2cmw_pkg::PH_BIT_LO, 1'b0);
              end else begin
                drv     = 1'b1;
                done    = 1'b1;
                nk      = nack_seen;
                bit_idx = '0;
                phase   = i2cmw_pkg::PH_IDLE;
              end
            end
            i2cmw_pkg::PH_STOP_A: begin
              scl = 1'b1;
              enter(i2cmw_pkg::PH_STOP_B, 1'b0);
            end
            i2cmw_pkg::PH_STOP_B: begin
              sda = 1'b1;
              enter(i2cmw_pkg::PH_STOP_C, 1'b1);
            end
            default: phase = i2cmw_pkg::PH_IDLE;
          endcase
        end
      end
      r.scl_out   = scl;
      r.sda_out   = sda;
      r.sda_drive = drv;
      r.busy      = (phase != i2cmw_pkg::PH_IDLE);
      r.ack_done  = done;
      r.nack      = nk;
      expected_levels.push_back(r);
    endfunction

    function void check_levels(logic [7:0] beat);
      string names [6] = '{"scl_out", "sda_out", "sda_drive", "busy_res", "ack_done", "nack"};
      logic [5:0] want;
      beats_seen++;
      if (expected_levels.size() == 0) begin
        $display("%0t: result beat %h arrived with nothing expected", $time, beat);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (beat[i] !== want[i]) begin
          $display("%0t: beat %0d %s expected %b got %b", $time, beats_seen, names[i],
                   want[i], beat[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [2:0] req_type, [10:3] data_byte, [11] sda_in, [15:12] zero
  logic [i2cmw_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready;
  // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] ack_done,
  // [5] nack, [7:6] zero
  logic [i2cmw_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [i2cmw_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [i2cmw_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  line_scoreboard sb;
  bit             no_gaps = 1'b0;
  ack_mode_t      ack_mode = ACK_ALL;

  i2c_master_write_bitbang i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic pick_sda();
    case (ack_mode)
      ACK_ALL:  return 1'b0;
      NACK_ALL: return 1'b1;
      default:  return 1'($urandom);
    endcase
  endfunction

  function automatic ack_mode_t draw_ack();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return ACK_ALL;
    if (r < 8) return ACK_MIXED;
    return NACK_ALL;
  endfunction

  task automatic drive_beat(input logic [2:0] req, input logic [7:0] data, input logic sda);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {4'b0, sda, data, req};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(req, data, sda);
  endtask

  // plain tick; now and then a command that must be dropped, or a spare code
  task automatic tick();
    logic [2:0] req;
    req = i2cmw_pkg::REQ_TICK;
    if ($urandom_range(0, 9) == 0)
      req = sb.busy() ? 3'($urandom_range(0, 7)) : 3'(REQ_SPARE_A + $urandom_range(0, 2));
    drive_beat(req, 8'($urandom), pick_sda());
  endtask

  task automatic issue(input logic [2:0] req, input logic [7:0] data);
    repeat ($urandom_range(0, 1)) tick();
    drive_beat(req, data, pick_sda());
    while (sb.busy()) tick();
  endtask

  task automatic transaction();
    int n;
    n = $urandom_range(1, 2);
    ack_mode = draw_ack();
    issue(i2cmw_pkg::REQ_START, 8'($urandom));
    ack_mode = draw_ack();
    issue(i2cmw_pkg::REQ_ADDR, 8'($urandom));
    repeat (n) begin
      ack_mode = draw_ack();
      issue(i2cmw_pkg::REQ_DATA, 8'($urandom));
    end
    issue(i2cmw_pkg::REQ_STOP, 8'($urandom));
  endtask

  task automatic write_reg_port(input i2cmw_pkg::cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // upper address bits are don't-care, so they get random values
  task automatic set_bus(input i2cmw_pkg::hp_t hp, input i2cmw_pkg::addr_t addr);
    logic [15:0] word;
    word      = 16'($urandom);
    word[6:0] = addr;
    write_reg_port(i2cmw_pkg::CFG_HALF_PERIOD, hp);
    write_reg_port(i2cmw_pkg::CFG_SLAVE_ADDR, word);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side; long holds at fixed beat counts fill the block up
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
      end
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_levels(out_tdata);
        if (sb.beats_seen == 400 || sb.beats_seen == 1500) hold = 120;
        else hold = no_gaps ? 0 : $urandom_range(0, 3);
      end
    end
  end

  initial begin
    i2cmw_pkg::hp_t hp;
    int             target;
    sb = new;
    sb.reset_bus();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values: 30 ticks per half period, 15 tick hold, address 0x68
    ack_mode = ACK_ALL;
    issue(i2cmw_pkg::REQ_START, 8'($urandom));
    settle();
    write_reg_port(i2cmw_pkg::CFG_HALF_PERIOD, 16'd1);
    issue(i2cmw_pkg::REQ_ADDR, 8'($urandom));
    settle();

    // directed pass, zero period runs as one tick
    set_bus(16'd0, 7'h7F);
    drive_beat(REQ_SPARE_A, 8'h00, 1'b0);
    drive_beat(REQ_SPARE_B, 8'hFF, 1'b1);
    drive_beat(REQ_SPARE_C, 8'h5A, 1'b0);
    issue(i2cmw_pkg::REQ_TICK, 8'hFF);
    issue(i2cmw_pkg::REQ_STOP, 8'h00);
    drive_beat(i2cmw_pkg::REQ_START, 8'h00, 1'b0);
    drive_beat(i2cmw_pkg::REQ_DATA, 8'hA5, 1'b0);
    while (sb.busy()) tick();
    issue(i2cmw_pkg::REQ_ADDR, 8'h00);
    issue(i2cmw_pkg::REQ_DATA, 8'h00);
    ack_mode = NACK_ALL;
    issue(i2cmw_pkg::REQ_DATA, 8'hFF);
    // start with SCL still low after the byte
    ack_mode = ACK_MIXED;
    issue(i2cmw_pkg::REQ_START, 8'hFF);
    issue(i2cmw_pkg::REQ_STOP, 8'h00);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: hp = 16'd1;
        1: hp = 16'd2;
        2: hp = 16'd3;
        3: hp = i2cmw_pkg::hp_t'($urandom_range(1, 4));
        4: hp = i2cmw_pkg::hp_t'($urandom_range(4, 6));
        default: hp = 16'd1;
      endcase
      set_bus(hp, (p == 0) ? 7'h00 : (p == 1) ? 7'h7F :
              i2cmw_pkg::addr_t'($urandom_range(0, 127)));
      no_gaps = (p == 3);
      target = sb.ticks_taken + 40;
      while (sb.ticks_taken < target) begin
        if ($urandom_range(0, 4) != 0) begin
          transaction();
        end else begin
          ack_mode = draw_ack();
          issue(3'($urandom_range(0, 7)), 8'($urandom));
        end
      end
      // some phases end mid-command so the next write lands in a segment
      if (p == 5 || $urandom_range(0, 2) != 0)
        while (sb.busy()) tick();
      settle();
    end

    // longest half period: only the opening ticks of a start
    set_bus(16'hFFFF, i2cmw_pkg::addr_t'($urandom_range(0, 127)));
    no_gaps = 1'b1;
    drive_beat(i2cmw_pkg::REQ_START, 8'($urandom), pick_sda());
    repeat (20) tick();
    settle();

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("i2c_master_write_bitbang test passed");
    end else begin
      $display("i2c_master_write_bitbang test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("i2c_master_write_bitbang test failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/i2cmw_pkg.sv
sv/i2cmw_core.sv
sv/i2c_master_write_bitbang.sv
bench/testbench.sv
